// ----- rtl/wpc_pkg.sv -----
// Package for the waterfall pixel colorizer: geometry constants, shared types
// and the elaboration-time build of the RGB565 rainbow table.
// No dependencies.
package wpc_pkg;

    localparam int LINE_LEN = 256;
    localparam int ROWS     = 320;

    localparam int COL_W = (LINE_LEN > 1) ? $clog2(LINE_LEN) : 1;
    localparam int ROW_W = $clog2(ROWS);

    localparam int SAMPLE_W  = 32;
    localparam int OFFSET_W  = 11;
    localparam int LEVEL_W   = 8;
    localparam int COLOR_W   = 16;
    localparam int PIX_COL_W = 8;
    localparam int PIX_ROW_W = 9;

    localparam logic [OFFSET_W-1:0] LOG_OFFSET_RESET = 11'd1250;
    localparam logic [LEVEL_W-1:0]  LEVEL_MAX        = 8'd255;

    localparam int NUM_KNOTS = 8;
    localparam int KNOT_POS [NUM_KNOTS] = '{'h00, 'h18, 'h38, 'h58, 'h78, 'h88, 'hc0, 'h100};
    localparam int KNOT_RGB [NUM_KNOTS][3] = '{
        '{68, 34, 153},
        '{68, 68, 221},
        '{17, 170, 187},
        '{34, 204, 170},
        '{105, 208, 37},
        '{170, 204, 34},
        '{210, 90, 16},
        '{238, 17, 0}
    };

    localparam int SPAN_0 = KNOT_POS[1] - KNOT_POS[0];
    localparam int SPAN_1 = KNOT_POS[2] - KNOT_POS[1];
    localparam int SPAN_2 = KNOT_POS[3] - KNOT_POS[2];
    localparam int SPAN_3 = KNOT_POS[4] - KNOT_POS[3];
    localparam int SPAN_4 = KNOT_POS[5] - KNOT_POS[4];
    localparam int SPAN_5 = KNOT_POS[6] - KNOT_POS[5];
    localparam int SPAN_6 = KNOT_POS[7] - KNOT_POS[6];

    typedef logic [COLOR_W-1:0] color_table_t [2**LEVEL_W];

    // line position of one beat, handed from the line tracker to the top
    typedef struct packed {
        logic [PIX_COL_W-1:0] column;
        logic [PIX_ROW_W-1:0] row;
        logic                 last;
        logic [PIX_ROW_W-1:0] scroll;
    } line_pos_t;

    function automatic int div_span(int k, int n);
        unique case (k)
            0:       return n / SPAN_0;
            1:       return n / SPAN_1;
            2:       return n / SPAN_2;
            3:       return n / SPAN_3;
            4:       return n / SPAN_4;
            5:       return n / SPAN_5;
            default: return n / SPAN_6;
        endcase
    endfunction

    // each of the two interpolation terms truncates on its own
    function automatic logic [7:0] lerp_ch(int k, int x, int c);
        int x0;
        int x1;
        int sum;
        x0  = KNOT_POS[k];
        x1  = KNOT_POS[k+1];
        sum = div_span(k, KNOT_RGB[k+1][c] * (x - x0)) + div_span(k, KNOT_RGB[k][c] * (x1 - x));
        return sum[7:0];
    endfunction

    function automatic color_table_t build_table();
        color_table_t t;
        int k;
        logic [7:0] r;
        logic [7:0] g;
        logic [7:0] b;
        for (int lvl = 0; lvl < 2**LEVEL_W; lvl++)
        begin
            k = 0;
            for (int i = 0; i < NUM_KNOTS - 1; i++)
            begin
                if (lvl >= KNOT_POS[i])
                begin
                    k = i;
                end
            end
            r = lerp_ch(k, lvl, 0);
            g = lerp_ch(k, lvl, 1);
            b = lerp_ch(k, lvl, 2);
            t[lvl] = {r[7:3], g[7:2], b[7:3]};
        end
        return t;
    endfunction

    localparam color_table_t COLOR_TABLE = build_table();

endpackage

// ----- rtl/wpc_level_map.sv -----
// Level mapper: exponent bits minus offset, clamped to a level, then the
// rainbow table lookup. Depends on wpc_pkg.
module wpc_level_map
(
    input  logic [wpc_pkg::SAMPLE_W-1:0] sample,
    input  logic [wpc_pkg::OFFSET_W-1:0] log_offset,
    output logic [wpc_pkg::COLOR_W-1:0]  color
);

    logic [wpc_pkg::OFFSET_W-1:0] field;
    logic [wpc_pkg::OFFSET_W-1:0] diff;
    logic [wpc_pkg::LEVEL_W-1:0]  level;

    assign field = sample[30:20];
    assign diff  = field - log_offset;

    // sign bit is dropped, so negative magnitudes map like positive ones
    always_comb
    begin
        priority if (field < log_offset)
        begin
            level = '0;
        end
        else if (diff > 11'(wpc_pkg::LEVEL_MAX))
        begin
            level = wpc_pkg::LEVEL_MAX;
        end
        else
        begin
            level = diff[wpc_pkg::LEVEL_W-1:0];
        end
    end

    assign color = wpc_pkg::COLOR_TABLE[level];

endmodule

// ----- rtl/wpc_line_tracker.sv -----
// Line tracker: column counter and scrolling row pointer of the waterfall.
// Depends on wpc_pkg.
module wpc_line_tracker
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                advance,
    output wpc_pkg::line_pos_t  pos
);

    logic [wpc_pkg::COL_W-1:0] col_reg;
    logic [wpc_pkg::COL_W-1:0] col_next;
    logic [wpc_pkg::ROW_W-1:0] row_reg;
    logic [wpc_pkg::ROW_W-1:0] row_next;
    logic [wpc_pkg::ROW_W-1:0] row_wrap;
    logic [wpc_pkg::ROW_W-1:0] scroll;
    logic                      last;

    assign last     = (col_reg == wpc_pkg::COL_W'(wpc_pkg::LINE_LEN - 1));
    assign row_wrap = (row_reg == '0) ? wpc_pkg::ROW_W'(wpc_pkg::ROWS - 1) : row_reg - 1'b1;
    assign scroll   = wpc_pkg::ROW_W'(wpc_pkg::ROWS - 1) - row_wrap;

    always_comb
    begin
        col_next = col_reg;
        row_next = row_reg;
        if (advance)
        begin
            if (last)
            begin
                col_next = '0;
                row_next = row_wrap;
            end
            else
            begin
                col_next = col_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= wpc_pkg::ROW_W'(wpc_pkg::ROWS - 1);
        end
        else
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    assign pos.column = wpc_pkg::PIX_COL_W'(col_reg);
    assign pos.row    = wpc_pkg::PIX_ROW_W'(row_reg);
    assign pos.last   = last;
    assign pos.scroll = last ? wpc_pkg::PIX_ROW_W'(scroll) : '0;

    // row pointer never leaves the display
    a_row_range: assert property (@(posedge clk) disable iff (!rst_n)
        row_reg <= wpc_pkg::ROW_W'(wpc_pkg::ROWS - 1))
        else $error("row pointer out of range");

    // a completed line restarts the column count
    a_col_restart: assert property (@(posedge clk) disable iff (!rst_n)
        advance && last |=> col_reg == '0)
        else $error("column count did not restart");

    // row pointer only moves at the end of a line
    a_row_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !(advance && last) |=> $stable(row_reg))
        else $error("row pointer moved mid-line");

endmodule

// ----- rtl/waterfall_pixel_colorizer.sv -----
// Waterfall pixel colorizer top: input register, level map and line tracker,
// result register. Depends on wpc_pkg, wpc_level_map, wpc_line_tracker.
// Path: an accepted input beat passes the input register, then the result register.
// Throughput: one beat per cycle unless the result side stalls; input register
// and result register each hold a beat: one more beat enters while a result waits.
// Reset: rst_n async active low; clears valids, column 0, row ROWS-1,
// log_offset 1250. The color table is constant logic.
module waterfall_pixel_colorizer
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        log_offset_wr_en,
    input  logic [10:0] log_offset_wr_data,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [31:0] s_axis_tdata,   // [31:0] sample_bits
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [47:0] m_axis_tdata,   // [15:0] pixel_color, [23:16] pixel_column,
                                        // [32:24] pixel_row, [41:33] scroll_offset, zero fill
    output logic        m_axis_tlast    // line_done
);

    logic [wpc_pkg::OFFSET_W-1:0] offset_reg;
    logic                         in_valid_reg;
    logic [wpc_pkg::SAMPLE_W-1:0] in_data_reg;
    logic                         out_valid_reg;
    logic [wpc_pkg::COLOR_W-1:0]  color_reg;
    wpc_pkg::line_pos_t           pos_reg;

    logic                         adv_out;
    logic                         adv_in;
    logic                         move;
    logic [wpc_pkg::COLOR_W-1:0]  color;
    wpc_pkg::line_pos_t           pos;

    assign adv_out       = !out_valid_reg || m_axis_tready;
    assign adv_in        = !in_valid_reg || adv_out;
    assign move          = in_valid_reg && adv_out;
    assign s_axis_tready = adv_in;

    wpc_level_map u_level_map
    (
        .sample     (in_data_reg),
        .log_offset (offset_reg),
        .color      (color)
    );

    wpc_line_tracker u_line_tracker
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .advance (move),
        .pos     (pos)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            offset_reg    <= wpc_pkg::LOG_OFFSET_RESET;
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (log_offset_wr_en)
            begin
                offset_reg <= log_offset_wr_data;
            end
            if (adv_in)
            begin
                in_valid_reg <= s_axis_tvalid;
            end
            if (adv_out)
            begin
                out_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv_in && s_axis_tvalid)
        begin
            in_data_reg <= s_axis_tdata;
        end
        if (move)
        begin
            color_reg <= color;
            pos_reg   <= pos;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = pos_reg.last;
    assign m_axis_tdata  = {6'd0, pos_reg.scroll, pos_reg.row, pos_reg.column, color_reg};

    // a held input beat is not dropped while the result side stalls
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid_reg && !adv_out |=> in_valid_reg && $stable(in_data_reg))
        else $error("input beat lost during stall");

    // line_done only on the last column
    a_last_col: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tlast |->
            m_axis_tdata[23:16] == wpc_pkg::PIX_COL_W'(wpc_pkg::LINE_LEN - 1))
        else $error("line_done off the last column");

    // scroll offset is zero mid-line
    a_scroll_zero: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tlast |-> m_axis_tdata[41:33] == '0)
        else $error("scroll offset set mid-line");

endmodule
